FILE: hdl/cra_pkg.sv
// shared constants, codes and types of the chunk reassembly tracker
`timescale 1ns / 1ps
package cra_pkg;

  localparam int unsigned STREAM_COUNT = 4;
  localparam int unsigned FRAME_BYTES  = 262144;
  localparam int unsigned CHUNK_BYTES  = 1024;
  localparam int unsigned CHUNK_SLOTS  = 256;
  localparam int unsigned HEADER_BYTES = 20;

  localparam int unsigned CHUNK_SHIFT     = $clog2(CHUNK_BYTES);
  localparam int unsigned ROW_BITS        = (CHUNK_SLOTS >= 64) ? 64 :
                                            (1 << $clog2(CHUNK_SLOTS));
  localparam int unsigned ROW_SHIFT       = $clog2(ROW_BITS);
  localparam int unsigned BIT_W           = (ROW_SHIFT > 0) ? ROW_SHIFT : 1;
  localparam int unsigned ROWS_PER_STREAM = (CHUNK_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned NUM_ROWS        = STREAM_COUNT * ROWS_PER_STREAM;
  localparam int unsigned ADDR_W          = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned RPS_W           = (ROWS_PER_STREAM > 1) ?
                                            $clog2(ROWS_PER_STREAM) : 1;
  localparam int unsigned STREAM_W        = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int unsigned CNT_W           = $clog2(CHUNK_SLOTS + 1);

  localparam logic [7:0] REG_MAGIC  = 8'd0;
  localparam logic [7:0] REG_FORMAT = 8'd1;

  typedef enum logic [2:0] {
    STAT_BAD_STREAM = 3'd0,
    STAT_SHORT      = 3'd1,
    STAT_BAD_MAGIC  = 3'd2,
    STAT_BAD_FORMAT = 3'd3,
    STAT_RANGE      = 3'd4,
    STAT_ACCEPTED   = 3'd5,
    STAT_COMPLETE   = 3'd6,
    STAT_DROPPED    = 3'd7
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [1:0]            stream_out;
    logic [STREAM_W-1:0]   sidx;
    logic                  slot_ok;
    logic [ADDR_W-1:0]     row_addr;
    logic [BIT_W-1:0]      bit_pos;
    logic [17:0]           wr_offset;
    logic [15:0]           wr_length;
    logic [31:0]           frame_length;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        write_enable;
    logic [17:0] write_offset;
    logic [15:0] write_length;
    logic [18:0] frame_length_out;
    logic [1:0]  stream_out;
  } result_t;

endpackage

FILE: hdl/cra_if.sv
// channel interfaces: chunk headers, results and register writes
`timescale 1ns / 1ps
interface cra_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stream;
  logic [15:0] packet_length;
  logic [31:0] magic;
  logic [7:0]  format;
  logic [31:0] frag_offset;
  logic [15:0] chunk_length;
  logic [31:0] frame_length;

  modport source (output valid, stream, packet_length, magic, format, frag_offset,
                  chunk_length, frame_length, input ready);
  modport sink   (input valid, stream, packet_length, magic, format, frag_offset,
                  chunk_length, frame_length, output ready);
endinterface

interface cra_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        write_enable;
  logic [17:0] write_offset;
  logic [15:0] write_length;
  logic [18:0] frame_length_out;
  logic [1:0]  stream_out;

  modport source (output valid, status, write_enable, write_offset, write_length,
                  frame_length_out, stream_out, input ready);
  modport sink   (input valid, status, write_enable, write_offset, write_length,
                  frame_length_out, stream_out, output ready);
endinterface

interface cra_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/cra_front.sv
// header checks, register file and slot classification
`timescale 1ns / 1ps
module cra_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  cra_in_if.sink        in_i,
  cra_cfg_if.sink       cfg_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output cra_pkg::item_t push_item_o
);
  import cra_pkg::*;

  logic [31:0] magic_q;
  logic [7:0]  format_q;
  logic [32:0] end_byte;
  logic [31:0] slot;
  logic [31:0] row_in;
  logic        bad_stream;
  logic        accepted;
  status_e     hdr_status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= '0;
      format_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MAGIC:  magic_q  <= cfg_i.data;
        REG_FORMAT: format_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign end_byte   = {1'b0, in_i.frag_offset} + 33'(in_i.chunk_length);
  assign slot       = in_i.frag_offset >> CHUNK_SHIFT;
  assign row_in     = slot >> ROW_SHIFT;
  assign bad_stream = 32'(in_i.stream) >= 32'(STREAM_COUNT);
  assign accepted   = (hdr_status == STAT_ACCEPTED);

  always_comb begin
    if (bad_stream) begin
      hdr_status = STAT_BAD_STREAM;
    end else if (32'(in_i.packet_length) < 32'(HEADER_BYTES)) begin
      hdr_status = STAT_SHORT;
    end else if (in_i.magic != magic_q) begin
      hdr_status = STAT_BAD_MAGIC;
    end else if (in_i.format != format_q) begin
      hdr_status = STAT_BAD_FORMAT;
    end else if (end_byte > 33'(FRAME_BYTES)) begin
      hdr_status = STAT_RANGE;
    end else begin
      hdr_status = STAT_ACCEPTED;
    end
  end

  assign push_item_o.status       = hdr_status;
  assign push_item_o.stream_out   = bad_stream ? 2'd0 : in_i.stream[1:0];
  assign push_item_o.sidx         = STREAM_W'(in_i.stream);
  assign push_item_o.slot_ok      = slot < 32'(CHUNK_SLOTS);
  assign push_item_o.row_addr     = ADDR_W'(ADDR_W'(push_item_o.sidx) * ADDR_W'(ROWS_PER_STREAM))
                                    + ADDR_W'(row_in);
  assign push_item_o.bit_pos      = BIT_W'(slot & 32'(ROW_BITS - 1));
  assign push_item_o.wr_offset    = accepted ? in_i.frag_offset[17:0] : 18'd0;
  assign push_item_o.wr_length    = accepted ? in_i.chunk_length : 16'd0;
  assign push_item_o.frame_length = in_i.frame_length;

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

FILE: hdl/cra_queue.sv
// two-entry queue between the classifier and the tracker
`timescale 1ns / 1ps
module cra_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cra_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cra_pkg::item_t pop_item_o
);
  import cra_pkg::*;

  localparam int unsigned DEPTH = 2;

  item_t       slot_q [DEPTH];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;

  assign push_ready_o = cnt_q != 2'(DEPTH);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_item_i;
  end

endmodule

FILE: hdl/cra_back.sv
// per-stream byte counts, chunk bitmap and completion check
`timescale 1ns / 1ps
module cra_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  cra_pkg::item_t pop_item_i,
  cra_res_if.source      res_o
);
  import cra_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]          state_q;
  item_t               cur_q;
  logic [31:0]         exp_q [STREAM_COUNT];
  logic [31:0]         rcv_q [STREAM_COUNT];
  logic [31:0]         exp_w_q;
  logic [31:0]         rcv_w_q;
  logic [CNT_W-1:0]    rem_q;
  logic [RPS_W-1:0]    row_q;
  logic [NUM_ROWS-1:0] row_vld_q;
  logic [ROW_BITS-1:0] mem [NUM_ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic                rd_vld_q;
  result_t             out_q;
  logic                out_vld_q;

  logic                out_vld_d;
  logic                out_free;
  logic                pop;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] mask;
  logic                wr_en;
  logic [ROW_BITS-1:0] wr_data;
  logic [31:0]         exp_cur;
  logic [31:0]         exp_n;
  logic [32:0]         rcv_sum;
  logic [31:0]         rcv_n;
  logic [32:0]         total;
  logic                row_ok;
  logic                row_last;
  logic                fin;
  status_e             fin_status;
  logic                clr;
  logic                chk_go;
  logic                chk_next;

  assign out_free    = !out_vld_q || res_o.ready;
  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign base        = ADDR_W'(ADDR_W'(cur_q.sidx) * ADDR_W'(ROWS_PER_STREAM));
  assign out_vld_d   = (out_vld_q && !res_o.ready) ||
                       (pop && (pop_item_i.status != STAT_ACCEPTED)) || fin;

  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_addr = pop_item_i.row_addr;
      S_CHK:   rd_addr = base + ADDR_W'(row_q) + ADDR_W'(1);
      default: rd_addr = base;
    endcase
  end

  assign row_data = rd_vld_q ? rd_data_q : '0;
  assign wr_en    = (state_q == S_UPD) && cur_q.slot_ok;
  assign wr_data  = row_data | (ROW_BITS'(1) << cur_q.bit_pos);

  assign exp_cur = exp_q[cur_q.sidx];
  assign exp_n   = (exp_cur == '0) ? cur_q.frame_length : exp_cur;
  assign rcv_sum = {1'b0, rcv_q[cur_q.sidx]} + 33'(cur_q.wr_length);
  assign rcv_n   = rcv_sum[32] ? '1 : rcv_sum[31:0];

  // slots needed by the frame, rounded up
  assign total = ({1'b0, exp_w_q} + 33'(CHUNK_BYTES - 1)) >> CHUNK_SHIFT;

  assign mask     = (32'(rem_q) >= 32'(ROW_BITS)) ? '1 : ~({ROW_BITS{1'b1}} << rem_q);
  assign row_ok   = (row_data & mask) == mask;
  assign row_last = 32'(rem_q) <= 32'(ROW_BITS);

  always_comb begin
    fin        = 1'b0;
    fin_status = STAT_ACCEPTED;
    clr        = 1'b0;
    chk_go     = 1'b0;
    chk_next   = 1'b0;
    unique case (state_q)
      S_CMP: begin
        if (rcv_w_q < exp_w_q) begin
          fin = 1'b1;
        end else if (total > 33'(CHUNK_SLOTS)) begin
          fin        = 1'b1;
          fin_status = STAT_DROPPED;
          clr        = 1'b1;
        end else if (total == '0) begin
          fin        = 1'b1;
          fin_status = STAT_COMPLETE;
          clr        = 1'b1;
        end else begin
          chk_go = 1'b1;
        end
      end
      S_CHK: begin
        if (!row_ok) begin
          fin        = 1'b1;
          fin_status = STAT_DROPPED;
          clr        = 1'b1;
        end else if (row_last) begin
          fin        = 1'b1;
          fin_status = STAT_COMPLETE;
          clr        = 1'b1;
        end else begin
          chk_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      row_vld_q <= '0;
      rem_q     <= '0;
      row_q     <= '0;
      for (int s = 0; s < STREAM_COUNT; s++) begin
        exp_q[s] <= '0;
        rcv_q[s] <= '0;
      end
    end else begin
      out_vld_q <= out_vld_d;
      unique case (state_q)
        S_IDLE: begin
          if (pop && (pop_item_i.status == STAT_ACCEPTED)) state_q <= S_UPD;
        end
        S_UPD: begin
          exp_q[cur_q.sidx] <= exp_n;
          rcv_q[cur_q.sidx] <= rcv_n;
          if (wr_en) row_vld_q[cur_q.row_addr] <= 1'b1;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (chk_go) begin
            rem_q   <= total[CNT_W-1:0];
            row_q   <= '0;
            state_q <= S_CHK;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_CHK: begin
          if (chk_next) begin
            rem_q <= rem_q - CNT_W'(ROW_BITS);
            row_q <= row_q + RPS_W'(1);
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (clr) begin
        exp_q[cur_q.sidx] <= '0;
        rcv_q[cur_q.sidx] <= '0;
        for (int k = 0; k < NUM_ROWS; k++) begin
          if (STREAM_W'(k / ROWS_PER_STREAM) == cur_q.sidx) row_vld_q[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_item_i;
      if (pop_item_i.status != STAT_ACCEPTED) begin
        out_q.status           <= pop_item_i.status;
        out_q.write_enable     <= 1'b0;
        out_q.write_offset     <= '0;
        out_q.write_length     <= '0;
        out_q.frame_length_out <= '0;
        out_q.stream_out       <= pop_item_i.stream_out;
      end
    end
    if (state_q == S_UPD) begin
      exp_w_q <= exp_n;
      rcv_w_q <= rcv_n;
    end
    if (fin) begin
      out_q.status           <= fin_status;
      out_q.write_enable     <= 1'b1;
      out_q.write_offset     <= cur_q.wr_offset;
      out_q.write_length     <= cur_q.wr_length;
      out_q.frame_length_out <= (fin_status == STAT_COMPLETE) ? exp_w_q[18:0] : 19'd0;
      out_q.stream_out       <= cur_q.stream_out;
    end
  end

  // bitmap rows
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cur_q.row_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= row_vld_q[rd_addr];
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.status           = out_q.status;
  assign res_o.write_enable     = out_q.write_enable;
  assign res_o.write_offset     = out_q.write_offset;
  assign res_o.write_length     = out_q.write_length;
  assign res_o.frame_length_out = out_q.frame_length_out;
  assign res_o.stream_out       = out_q.stream_out;

  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_vld_q)
    else $error("result register busy while a chunk is in work");

  a_fin_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_vld_q)
    else $error("finished chunk produced no result");

  a_chk_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (rem_q != '0 && 32'(row_q) < 32'(ROWS_PER_STREAM)))
    else $error("bitmap scan ran past its rows");

  a_upd_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (cur_q.status == STAT_ACCEPTED))
    else $error("rejected chunk reached the tracker update");

endmodule

FILE: hdl/chunk_reassembly_tracker.sv
// top level of the chunk reassembly tracker
// path: a rejected header passes the queue entry and the result register; an accepted chunk
// also the update and compare states, and a frame-closing one a check state per 64-slot row checked
// throughput: one rejected header per cycle while results are taken; an accepted chunk blocks
// new ones through its bitmap read-modify-write and the row-by-row completion scan
// reset: asynchronous, clears control state, byte counts and row valid flags; bitmap needs no pass
`timescale 1ns / 1ps
module chunk_reassembly_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  cra_in_if.sink     in_i,
  cra_cfg_if.sink    cfg_i,
  cra_res_if.source  res_o
);
  import cra_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  cra_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  cra_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  cra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_o       (res_o)
  );

endmodule
